// ===== hdl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Command and status codes, field widths and the control bundle that is
// passed from the top level to the pointer unit.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;

    // Front and back read as this value while the queue is empty
    localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd999999;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY     = 3'd0,
        CMD_INS_FRONT = 3'd1,
        CMD_INS_BACK  = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_BACK  = 3'd4,
        CMD_CLEAR     = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic accept;
        cmd_t cmd;
    } ptr_ctl_t;

endpackage

// ===== hdl/dq_ifs.sv =====
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if: command and result channels
// Valid/ready channels; a transaction completes when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface dq_req_if
    import dq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface dq_rsp_if
    import dq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] last_value;
    logic [COUNT_W-1:0]       count;

    modport source (output valid, output status, output first_value,
                    output last_value, output count, input ready);
    modport sink   (input valid, input status, input first_value,
                    input last_value, input count, output ready);
endinterface

// ===== hdl/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram: slot memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module dq_ram
    import dq_pkg::*;
#(
    parameter int  DEPTH = CAPACITY_DEF,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr_a,
    input  logic [AW-1:0]            rd_addr_b,
    output logic signed [DATA_W-1:0] rd_data_a,
    output logic signed [DATA_W-1:0] rd_data_b
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== hdl/dq_ptr.sv =====
// ----------------------------------------------------------------------------
// dq_ptr: ring pointers and occupancy
// Decode the command, move the front or back pointer, update the count and
// produce the slot write and the read addresses of the two ends.
// ----------------------------------------------------------------------------
module dq_ptr
    import dq_pkg::*;
#(
    parameter int  DEPTH = CAPACITY_DEF,
    localparam int AW    = $clog2(DEPTH),
    localparam int OW    = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ptr_ctl_t      ctl,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [AW-1:0] rd_front,
    output logic [AW-1:0] rd_back,
    output logic [OW-1:0] occ,
    output status_t       status
);

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] back_reg, back_next;
    logic [OW-1:0] occ_reg, occ_next;
    status_t       status_reg, status_next;

    logic          full, empty, ins_ok;
    logic [AW-1:0] front_up, front_dn, back_up, back_dn;

    assign full  = (occ_reg == OW'(DEPTH));
    assign empty = (occ_reg == '0);

    assign front_up = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dn = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign back_up  = (back_reg == AW'(DEPTH - 1)) ? '0 : back_reg + 1'b1;
    assign back_dn  = (back_reg == '0) ? AW'(DEPTH - 1) : back_reg - 1'b1;

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        occ_next    = occ_reg;
        status_next = ST_OK;
        ins_ok      = 1'b0;
        wr_addr     = back_reg;
        case (ctl.cmd)
            CMD_INS_FRONT:
            begin
                wr_addr = front_dn;
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    ins_ok     = 1'b1;
                    front_next = front_dn;
                    occ_next   = occ_reg + 1'b1;
                end
            end
            CMD_INS_BACK:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    ins_ok    = 1'b1;
                    back_next = back_up;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            CMD_REM_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    front_next = front_up;
                    occ_next   = occ_reg - 1'b1;
                end
            end
            CMD_REM_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    back_next = back_dn;
                    occ_next  = occ_reg - 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                front_next = '0;
                back_next  = '0;
                occ_next   = '0;
            end
            default:
            begin
                // query and unused codes leave the state alone
            end
        endcase
    end

    assign wr_en = ctl.accept && ins_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            back_reg   <= '0;
            occ_reg    <= '0;
            status_reg <= ST_OK;
        end
        else if (ctl.accept)
        begin
            front_reg  <= front_next;
            back_reg   <= back_next;
            occ_reg    <= occ_next;
            status_reg <= status_next;
        end
    end

    // Back pointer sits one past the last element
    assign rd_front = front_reg;
    assign rd_back  = back_dn;
    assign occ      = occ_reg;
    assign status   = status_reg;

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of signed 32-bit values
// Ring of CAPACITY slots in a synchronous RAM with front/back pointers.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction (query, insert front, insert
//   back, remove front, remove back, clear) plus the value to insert.
//   rsp returns one result per command: status, front and back elements
//   after the command (-999999 when empty) and the element count.
// Timing:
//   A command accepted at a clock edge updates pointers and writes the slot
//   at that edge; S_READ then reads both ends from the slot RAM and S_LOAD
//   loads the result register once it is free or being drained. req.ready
//   is high again in the cycle after the result is loaded, so the next command
//   can enter while the previous result still waits on rsp.
//   The order is set by the slot RAM: write, then a registered read.
// Reset:
//   Pointers and count return to zero, no result is pending. Slot contents
//   are not cleared; data from unoccupied slots never reaches rsp.
// Stall:
//   If rsp is stalled when a second result is ready, hold it in the read
//   registers and keep req.ready low until the result register frees up.
// ----------------------------------------------------------------------------
module double_ended_queue_top
    import dq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg, state_next;

    ptr_ctl_t                 ctl;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_front;
    logic [AW-1:0]            rd_back;
    logic [OW-1:0]            occ;
    status_t                  status;
    logic signed [DATA_W-1:0] rd_data_a;
    logic signed [DATA_W-1:0] rd_data_b;
    logic                     accept;
    logic                     load;

    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      status_reg;
    logic signed [DATA_W-1:0] first_reg;
    logic signed [DATA_W-1:0] last_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [OW+COUNT_W-1:0]    occ_wide;

    // Take a command only while no other command is in flight
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign ctl.accept = accept;
    assign ctl.cmd    = cmd_t'(req.command);

    dq_ptr #(
        .DEPTH (CAPACITY)
    ) u_ptr (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_front (rd_front),
        .rd_back  (rd_back),
        .occ      (occ),
        .status   (status)
    );

    dq_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (req.value),
        .rd_en     (state_reg == S_READ),
        .rd_addr_a (rd_front),
        .rd_addr_b (rd_back),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Load the result once the result register is free or being drained
    assign load = (state_reg == S_LOAD) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Count field carries the low bits of the occupancy
    assign occ_wide = {{COUNT_W{1'b0}}, occ};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status;
            count_reg  <= occ_wide[COUNT_W-1:0];
            if (occ == '0)
            begin
                first_reg <= EMPTY_MARK;
                last_reg  <= EMPTY_MARK;
            end
            else
            begin
                first_reg <= rd_data_a;
                last_reg  <= rd_data_b;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.first_value = first_reg;
    assign rsp.last_value  = last_reg;
    assign rsp.count       = count_reg;

    // Occupancy never exceeds the ring size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= OW'(CAPACITY))
        else $error("occupancy above capacity");

    // A fresh result only follows the load state
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LOAD))
        else $error("result raised outside load");

    // Underflow only reported on an empty queue
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_UNDERFLOW) |->
            (rsp.count == '0) && (rsp.first_value == EMPTY_MARK))
        else $error("underflow on non-empty queue");

    // No command enters while a result waits to be loaded
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) && !load |=> (state_reg == S_LOAD) && !req.ready)
        else $error("command taken during pending load");

endmodule

// ===== tb/deque_result_checker.sv =====
// ----------------------------------------------------------------------------
// deque_result_checker: result predictor and comparator for the deque
// Watches the command and result channels, keeps its own ring of CAPACITY
// values with front/back pointers, and compares every result transaction
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module deque_result_checker
    import dq_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    dq_req_if    req,
    dq_rsp_if    rsp,
    output int   fail_total,
    output int   outstanding
);

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] first_value;
        logic signed [DATA_W-1:0] last_value;
        logic [COUNT_W-1:0]       count;
    } deque_result_t;

    logic signed [DATA_W-1:0] ring [DEPTH];
    int                       head_idx;
    int                       tail_idx;     // one past the back element
    int                       fill;
    deque_result_t            result_q [$];
    deque_result_t            want;
    int                       fails;
    int                       seen;

    function automatic deque_result_t apply_command(logic [CMD_W-1:0] code,
                                                    logic signed [DATA_W-1:0] val);
        deque_result_t r;
        r.status = ST_OK;
        case (code)
            CMD_INS_FRONT:
                if (fill >= DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    head_idx       = (head_idx + DEPTH - 1) % DEPTH;
                    ring[head_idx] = val;
                    fill++;
                end
            CMD_INS_BACK:
                if (fill >= DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    ring[tail_idx] = val;
                    tail_idx       = (tail_idx + 1) % DEPTH;
                    fill++;
                end
            CMD_REM_FRONT:
                if (fill == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    head_idx = (head_idx + 1) % DEPTH;
                    fill--;
                end
            CMD_REM_BACK:
                if (fill == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                    fill--;
                end
            CMD_CLEAR:
            begin
                head_idx = 0;
                tail_idx = 0;
                fill     = 0;
            end
            default: ;
        endcase
        if (fill != 0)
        begin
            r.first_value = ring[head_idx];
            r.last_value  = ring[(tail_idx + DEPTH - 1) % DEPTH];
        end
        else
        begin
            r.first_value = EMPTY_MARK;
            r.last_value  = EMPTY_MARK;
        end
        r.count = COUNT_W'(fill);
        return r;
    endfunction

    task automatic note_field(string field, longint exp_val, longint got_val);
        if (exp_val != got_val)
        begin
            fails++;
            if (fails <= 10)
                $display("result %0d: %s expected %0d, got %0d",
                         seen, field, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
            fails    = 0;
            seen     = 0;
            result_q.delete();
            fail_total  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // results leave before the command of this edge is predicted
            if (rsp.valid && rsp.ready)
            begin
                if (result_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("result %0d: arrived with nothing pending", seen);
                end
                else
                begin
                    want = result_q.pop_front();
                    note_field("status", want.status, rsp.status);
                    note_field("first_value", want.first_value, rsp.first_value);
                    note_field("last_value", want.last_value, rsp.last_value);
                    note_field("count", want.count, rsp.count);
                end
                seen++;
            end
            if (req.valid && req.ready)
                result_q.push_back(apply_command(req.command, req.value));
            fail_total  <= fails;
            outstanding <= result_q.size();
        end
    end

endmodule

// ===== tb/tb_double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top: stimulus and verdict for the deque
// Runs a directed opening over empty, wrap, extreme and unused-code cases,
// then phases of random runs (fill, drain and mixed) under varying sender
// gaps and receiver stalls; deque_result_checker does all the comparing.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
    import dq_pkg::*;

    // command codes the block does not define; they must behave as a query
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // Each phase overshoots this by about half a run on average
    localparam int RUN_ITEMS = 232;

    logic clk;
    logic rst_n;
    int   gap_pct;
    int   stall_pct;
    int   fail_total;
    int   outstanding;
    int   guard;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deque_result_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_total  (fail_total),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit: far beyond the slowest legal run of about 1050 commands
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    // Result side: drop ready at random with the current stall rate
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Issue one command transaction. Idle cycles come first, with valid low;
    // otherwise valid stays high straight into the next transaction.
    task automatic send_command(input logic [CMD_W-1:0] code,
                                input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= code;
        req_ch.value   <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Hold the command channel idle until every predicted result is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly random words, with the extremes and the empty marker mixed in
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            4:       return EMPTY_MARK;
            default: return $urandom;
        endcase
    endfunction

    // Mixed traffic, leaning towards growth or shrinkage
    function automatic logic [CMD_W-1:0] pick_command(input bit grow);
        int w;
        w = $urandom_range(99);
        if (w < 2)
            return $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
        if (w < 4)
            return CMD_CLEAR;
        if (w < 10)
            return CMD_QUERY;
        if (w < (grow ? 75 : 30))
            return $urandom_range(1) ? CMD_INS_FRONT : CMD_INS_BACK;
        return $urandom_range(1) ? CMD_REM_FRONT : CMD_REM_BACK;
    endfunction

    // Runs of related commands. A fill run of 68 inserts always reaches a
    // full deque and overflows; a drain run of 68 removals always empties it
    // and underflows. Mixed runs wander the pointers around the ring.
    task automatic random_runs(input int total);
        int sent;
        int run_len;
        int flavour;
        logic [CMD_W-1:0] code;
        sent = 0;
        while (sent < total)
        begin
            flavour = $urandom_range(9);
            run_len = (flavour < 2) ? 68 : $urandom_range(60, 8);
            for (int i = 0; i < run_len; i++)
            begin
                case (flavour)
                    0:       code = $urandom_range(1) ? CMD_INS_FRONT : CMD_INS_BACK;
                    1:       code = $urandom_range(1) ? CMD_REM_FRONT : CMD_REM_BACK;
                    default: code = pick_command(flavour < 6);
                endcase
                send_command(code, pick_value());
            end
            sent += run_len;
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_QUERY;
        req_ch.value   <= '0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: empty deque first, then extremes at both ends
        send_command(CMD_QUERY, 32'sd5);
        send_command(CMD_REM_FRONT, 32'sd0);
        send_command(CMD_REM_BACK, 32'sd0);
        send_command(CMD_INS_FRONT, 32'sh7FFF_FFFF);   // front pointer wraps
        send_command(CMD_INS_BACK, 32'sh8000_0000);
        send_command(CMD_INS_FRONT, 32'sd0);
        send_command(CMD_INS_BACK, -32'sd1);
        send_command(CMD_INS_BACK, EMPTY_MARK);        // stored value equals marker
        send_command(CMD_QUERY, 32'sh5555_5555);
        send_command(CMD_SPARE_A, 32'sh1234_5678);
        send_command(CMD_SPARE_B, -32'sd1);
        send_command(CMD_REM_FRONT, 32'sd0);
        send_command(CMD_REM_BACK, 32'sd0);
        send_command(CMD_REM_FRONT, 32'sd0);
        send_command(CMD_REM_BACK, 32'sd0);
        send_command(CMD_REM_BACK, 32'sd0);            // last one leaves
        send_command(CMD_REM_FRONT, 32'sd0);           // underflow again
        send_command(CMD_INS_BACK, 32'sh5555_5555);
        send_command(CMD_INS_FRONT, 32'shAAAA_AAAA);
        send_command(CMD_CLEAR, 32'sd0);
        send_command(CMD_QUERY, 32'sd0);
        send_command(CMD_REM_BACK, 32'sd0);            // underflow after clear
        send_command(CMD_INS_FRONT, 32'sd1);
        send_command(CMD_REM_BACK, 32'sd0);
        drain_results();

        // Random phases: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 63; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 63; end
                default: begin gap_pct = 22; stall_pct = 22; end
            endcase
            random_runs(RUN_ITEMS);
            drain_results();
        end

        // Let the last results through, then give the verdict
        stall_pct = 0;
        req_ch.valid <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (fail_total == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dq_pkg.sv
hdl/dq_ifs.sv
hdl/dq_ram.sv
hdl/dq_ptr.sv
hdl/double_ended_queue_top.sv
tb/deque_result_checker.sv
tb/tb_double_ended_queue_top.sv
